/* sv/mema_pkg.sv */
`timescale 1ns / 1ps
package mema_pkg;
    // config register addresses (byte address / 4)
    localparam logic [0:0] REG_OBS_CODE  = 1'b0;
    localparam logic [0:0] REG_PRED_CODE = 1'b1;
    localparam int unsigned PERCENT_SCALE = 100;

    // back end sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_REL  = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;
endpackage

/* sv/mema_if.sv */
`timescale 1ns / 1ps
interface mema_in_if #(parameter int SW = 16);
    logic          valid;
    logic          ready;
    logic [SW-1:0] observed;
    logic [SW-1:0] predicted;
    logic          in_validation;
    logic          last_point;
    modport source (output valid, observed, predicted, in_validation, last_point,
                    input ready);
    modport sink   (input valid, observed, predicted, in_validation, last_point,
                    output ready);
endinterface

interface mema_out_if #(parameter int CW = 21);
    logic          valid;
    logic          ready;
    logic [31:0]   mean_square_error;
    logic [15:0]   root_mean_square_error;
    logic [15:0]   mean_absolute_error;
    logic [31:0]   mean_percent_error;
    logic [CW-1:0] valid_count;
    logic [CW-1:0] percent_count;
    modport source (output valid, mean_square_error, root_mean_square_error,
                    mean_absolute_error, mean_percent_error, valid_count,
                    percent_count, input ready);
    modport sink   (input valid, mean_square_error, root_mean_square_error,
                    mean_absolute_error, mean_percent_error, valid_count,
                    percent_count, output ready);
endinterface

/* sv/masked_error_metrics_accumulator.sv */
`timescale 1ns / 1ps
// Masked error metrics accumulator.
// Input channel in_ch carries observed/predicted signed samples with the
// in_validation and last_point flags; out_ch carries one result word per
// grid, sent after the word flagged last_point.
// Config is an APB-style port: address 0 holds the observed missing code,
// address 4 the predicted missing code; both reset to the most negative code.
// A two-entry queue decouples the front (masking, |o-p|) from the back end.
// In the back end a validation word first runs a relative divide on the
// shared bit-serial divider, whose width W is the widest dividend:
// max(2*SAMPLE_WIDTH+MAX_POINTS_LOG2+1, MAX_POINTS_LOG2+39), 59 by default.
// The last word adds three divides, a bit-pair square root and a load of
// the output register before out_ch goes valid; a divide by a zero count
// is cut short and gives zero.
// A finished result sits in the output register and the sums clear as it
// is loaded; the back end goes on with the next grid and holds only when a
// second result is ready, then the queue fills and in_ch.ready drops.
// Reset (synchronous, active low) clears sums, counts and queue and sets both codes to the most negative code.
module masked_error_metrics_accumulator #(
    parameter int MAX_POINTS_LOG2 = 20,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mema_in_if.sink     in_ch,
    mema_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mema_pkg::*;
    localparam int SW = SAMPLE_WIDTH;

    logic [SW-1:0] r_obs_code, r_pred_code;
    logic          w_q_valid, w_q_pop, w_q_use, w_q_rel, w_q_last;
    logic [SW:0]   w_q_ad, w_q_ao;

    assign pready = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_code  <= {1'b1, {(SW-1){1'b0}}};
            r_pred_code <= {1'b1, {(SW-1){1'b0}}};
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_OBS_CODE) r_obs_code <= pwdata[SW-1:0];
            else r_pred_code <= pwdata[SW-1:0];
        end
    end

    // config readback
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_OBS_CODE) prdata[SW-1:0] = r_obs_code;
        else prdata[SW-1:0] = r_pred_code;
    end

    mema_front #(.SW(SW)) u_front (
        .i_clk, .i_rst_n, .i_obs_code(r_obs_code), .i_pred_code(r_pred_code),
        .in_ch, .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_use(w_q_use),
        .o_q_rel(w_q_rel), .o_q_last(w_q_last), .o_q_ad(w_q_ad), .o_q_ao(w_q_ao)
    );

    mema_back #(.SW(SW), .PL(MAX_POINTS_LOG2)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_q_valid), .o_q_pop(w_q_pop),
        .i_q_use(w_q_use), .i_q_rel(w_q_rel), .i_q_last(w_q_last),
        .i_q_ad(w_q_ad), .i_q_ao(w_q_ao), .out_ch
    );
endmodule

/* sv/mema_front.sv */
`timescale 1ns / 1ps
// front: mask missing pairs, form |o-p|, queue words for the back end
module mema_front #(
    parameter int SW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [SW-1:0] i_obs_code,
    input  logic [SW-1:0] i_pred_code,
    mema_in_if.sink       in_ch,
    // queue head
    output logic          o_q_valid,
    input  logic          i_q_pop,
    output logic          o_q_use,
    output logic          o_q_rel,
    output logic          o_q_last,
    output logic [SW:0]   o_q_ad,
    output logic [SW:0]   o_q_ao
);
    localparam int QW = 3 + 2 * (SW + 1);

    logic [QW-1:0] r_q0, r_q1;
    logic [1:0]    r_cnt;
    logic [QW-1:0] w_word;
    logic          w_push;
    logic          w_use;
    logic signed [SW:0] w_diff;
    logic [SW:0]   w_ad, w_ao;

    // classify the incoming word
    always_comb begin
        w_use  = (in_ch.observed != i_obs_code) && (in_ch.predicted != i_pred_code);
        w_diff = $signed({in_ch.observed[SW-1], in_ch.observed})
               - $signed({in_ch.predicted[SW-1], in_ch.predicted});
        w_ad   = w_diff[SW] ? (~w_diff + 1'b1) : w_diff;
        w_ao   = in_ch.observed[SW-1] ? (~{1'b1, in_ch.observed} + 1'b1)
                                      : {1'b0, in_ch.observed};
        w_word = {w_use, w_use & in_ch.in_validation & (in_ch.observed != '0),
                  in_ch.last_point, w_ad, w_ao};
    end

    assign in_ch.ready = (r_cnt != 2'd2);
    assign w_push = in_ch.valid && in_ch.ready;

    // two-entry queue, head in r_q0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
        if (i_q_pop) begin
            r_q0 <= (r_cnt == 2'd2) ? r_q1 : w_word;
            if (w_push) r_q1 <= w_word;
        end else if (w_push) begin
            if (r_cnt == 2'd0) r_q0 <= w_word;
            else r_q1 <= w_word;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign {o_q_use, o_q_rel, o_q_last, o_q_ad, o_q_ao} = r_q0;
endmodule

/* sv/mema_back.sv */
`timescale 1ns / 1ps
// back: relative divide, accumulate, and at end of grid divide and root
module mema_back #(
    parameter int SW = 16,
    parameter int PL = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  logic        i_q_use,
    input  logic        i_q_rel,
    input  logic        i_q_last,
    input  logic [SW:0] i_q_ad,
    input  logic [SW:0] i_q_ao,
    mema_out_if.source  out_ch
);
    import mema_pkg::*;
    localparam int CW  = PL + 1;
    localparam int SQW = 2 * SW + PL + 1;
    localparam int ABW = SW + PL + 1;
    localparam int RLW = 32 + PL;
    localparam int PCW = RLW + 7;
    // shared divider width covers all four dividends
    localparam int DW0 = (SQW > ABW) ? SQW : ABW;
    localparam int DW1 = (DW0 > PCW) ? DW0 : PCW;
    localparam int DW  = (DW1 > SW + 17) ? DW1 : SW + 17;
    localparam int DCW = $clog2(DW + 1);

    t_state r_st;
    logic [SQW-1:0] r_sq;
    logic [ABW-1:0] r_ab;
    logic [RLW-1:0] r_rl;
    logic [CW-1:0]  r_pc, r_rc;
    logic           r_q_rel, r_q_last;
    logic [2*SW+1:0] r_ad2;
    // divider
    logic [DW-1:0]  r_dq;
    logic [DW:0]    r_rem;
    logic [DW-1:0]  r_dsor;
    logic [DCW-1:0] r_dbit;
    logic [1:0]     r_phase;
    logic [DW:0]    w_trial;
    // root
    logic [31:0]    r_rv;
    logic [31:0]    r_root;
    logic [31:0]    r_rbit;
    logic [31:0]    w_rsum;
    // results
    logic [31:0]    r_msq, r_pct;
    logic [15:0]    r_mab;
    logic [PCW-1:0] w_pnum;

    assign o_q_pop = (r_st == ST_IDLE) && i_q_valid;
    assign w_trial = {r_rem[DW-1:0], r_dq[DW-1]};
    assign w_rsum  = r_root + r_rbit;
    assign w_pnum  = PCW'(r_rl) * PCW'(PERCENT_SCALE);

    // back end sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_sq <= '0; r_ab <= '0; r_rl <= '0; r_pc <= '0; r_rc <= '0;
            out_ch.valid <= 1'b0;
        end else begin
            // output register drains when the receiver takes the word
            if (out_ch.valid && out_ch.ready && r_st != ST_OUT) out_ch.valid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_q_rel  <= i_q_rel;
                        r_q_last <= i_q_last;
                        r_ad2    <= i_q_use ? (2*SW+2)'(i_q_ad) * (2*SW+2)'(i_q_ad) : '0;
                        if (i_q_use) begin
                            r_pc <= r_pc + 1'b1;
                            r_ab <= r_ab + ABW'(i_q_ad);
                        end
                        if (i_q_rel) begin
                            // relative divide (ad<<16)/ao
                            r_dq    <= DW'({i_q_ad, 16'd0});
                            r_dsor  <= DW'(i_q_ao);
                            r_rem   <= '0;
                            r_dbit  <= DCW'(DW);
                            r_st    <= ST_REL;
                        end else begin
                            r_st <= ST_ACC;
                        end
                    end
                end
                ST_REL: begin
                    // one quotient bit per cycle
                    if (w_trial >= {1'b0, r_dsor}) begin
                        r_rem <= w_trial - {1'b0, r_dsor};
                        r_dq  <= {r_dq[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_dq  <= {r_dq[DW-2:0], 1'b0};
                    end
                    r_dbit <= r_dbit - 1'b1;
                    if (r_dbit == DCW'(1)) r_st <= ST_ACC;
                end
                ST_ACC: begin
                    r_sq <= r_sq + SQW'(r_ad2);
                    if (r_q_rel) begin
                        r_rl <= r_rl + ((|r_dq[DW-1:32]) ? RLW'(32'hFFFF_FFFF)
                                                         : RLW'(r_dq[31:0]));
                        r_rc <= r_rc + 1'b1;
                    end
                    if (r_q_last) begin
                        r_phase <= 2'd0;
                        r_dq    <= DW'(r_sq + SQW'(r_ad2));
                        r_dsor  <= DW'(r_pc);
                        r_rem   <= '0;
                        r_dbit  <= DCW'(DW);
                        r_msq <= '0; r_mab <= '0; r_pct <= '0;
                        r_st    <= ST_DIV;
                    end else begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (r_dbit != '0) begin
                        if (r_dsor != '0) begin
                            if (w_trial >= {1'b0, r_dsor}) begin
                                r_rem <= w_trial - {1'b0, r_dsor};
                                r_dq  <= {r_dq[DW-2:0], 1'b1};
                            end else begin
                                r_rem <= w_trial;
                                r_dq  <= {r_dq[DW-2:0], 1'b0};
                            end
                            r_dbit <= r_dbit - 1'b1;
                        end else begin
                            r_dq   <= '0;
                            r_dbit <= '0;
                        end
                    end else begin
                        r_rem  <= '0;
                        r_dbit <= DCW'(DW);
                        r_phase <= r_phase + 1'b1;
                        case (r_phase)
                            2'd0: begin
                                r_msq  <= (|r_dq[DW-1:32]) ? 32'hFFFF_FFFF : r_dq[31:0];
                                r_dq   <= DW'(r_ab);
                            end
                            2'd1: begin
                                r_mab  <= (|r_dq[DW-1:16]) ? 16'hFFFF : r_dq[15:0];
                                r_dq   <= DW'(w_pnum);
                                r_dsor <= DW'(r_rc);
                            end
                            default: begin
                                r_pct  <= (|r_dq[DW-1:32]) ? 32'hFFFF_FFFF : r_dq[31:0];
                                r_rv   <= r_msq;
                                r_root <= '0;
                                r_rbit <= 32'h4000_0000;
                                r_st   <= ST_SQRT;
                            end
                        endcase
                    end
                end
                ST_SQRT: begin
                    // bit-pair restoring square root
                    if (r_rbit != '0) begin
                        if (r_rv >= w_rsum) begin
                            r_rv   <= r_rv - w_rsum;
                            r_root <= (r_root >> 1) + r_rbit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_rbit <= r_rbit >> 2;
                    end else begin
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hand the result to the output register once it is free
                    if (!out_ch.valid || out_ch.ready) begin
                        out_ch.mean_square_error      <= r_msq;
                        out_ch.root_mean_square_error <= r_root[15:0];
                        out_ch.mean_absolute_error    <= r_mab;
                        out_ch.mean_percent_error     <= r_pct;
                        out_ch.valid_count            <= r_pc;
                        out_ch.percent_count          <= r_rc;
                        out_ch.valid <= 1'b1;
                        r_sq <= '0; r_ab <= '0; r_rl <= '0; r_pc <= '0; r_rc <= '0;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

/* sv/mema_checker.sv */
`timescale 1ns / 1ps
// port-level checks
module mema_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] msq,
    input logic [15:0] rms,
    input logic [20:0] pc,
    input logic [31:0] pct,
    input logic [20:0] rc,
    input logic        pready
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(msq))
        else $error("result dropped under stall");
    // empty grid gives zero mean square and root mean square error
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && pc == '0 |-> msq == '0 && rms == '0)
        else $error("nonzero mean with zero count");
    a_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && rc == '0 |-> pct == '0)
        else $error("nonzero percent with zero count");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> rc <= pc)
        else $error("percent count exceeds valid count");
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind masked_error_metrics_accumulator mema_checker u_chk (
    .i_clk, .i_rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .msq(out_ch.mean_square_error), .rms(out_ch.root_mean_square_error),
    .pc(out_ch.valid_count[20:0]), .pct(out_ch.mean_percent_error),
    .rc(out_ch.percent_count[20:0]), .pready
);
